[src/sbl_pkg.sv]
`default_nettype none

package sbl_pkg;

  localparam int COORD_BITS = 12;
  localparam int STAT_BITS  = 15;
  localparam int TRK_BITS   = (COORD_BITS + 2 > STAT_BITS) ? COORD_BITS + 2 : STAT_BITS;
  localparam int PIX_BITS   = 8;

  localparam logic [PIX_BITS-1:0]   PIX_TRANSPARENT = PIX_BITS'(255);
  localparam logic [COORD_BITS-1:0] SCREEN_RESET    = COORD_BITS'(200);
  localparam logic [TRK_BITS-1:0]   TRK_LO_INIT     = TRK_BITS'(10000);
  localparam logic [TRK_BITS-1:0]   TRK_HI_INIT     = TRK_BITS'(-10000);

  localparam int IN_RAW_BITS  = 2 * (COORD_BITS + 1) + 4 * COORD_BITS + 1 + PIX_BITS;
  localparam int IN_BITS      = ((IN_RAW_BITS + 7) / 8) * 8;
  localparam int IN_PAD_BITS  = IN_BITS - IN_RAW_BITS;
  localparam int OUT_RAW_BITS = 1 + 2 * COORD_BITS + PIX_BITS + 4 * STAT_BITS;
  localparam int OUT_BITS     = ((OUT_RAW_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS = OUT_BITS - OUT_RAW_BITS;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic REG_SCREEN_COLS = 1'b0;
  localparam logic REG_SCREEN_ROWS = 1'b1;

  typedef struct packed {
    logic [IN_PAD_BITS-1:0] pad;
    logic [PIX_BITS-1:0]    pixel;
    logic [COORD_BITS-1:0]  src_row;
    logic [COORD_BITS-1:0]  src_col;
    logic                   mirrored;
    logic [COORD_BITS-1:0]  sprite_rows;
    logic [COORD_BITS-1:0]  sprite_cols;
    logic [COORD_BITS:0]    place_y;
    logic [COORD_BITS:0]    place_x;
  } sbl_in_t;

  typedef struct packed {
    logic [OUT_PAD_BITS-1:0]     pad;
    logic signed [STAT_BITS-1:0] highest_col_seen;
    logic signed [STAT_BITS-1:0] lowest_col_seen;
    logic signed [STAT_BITS-1:0] highest_row_seen;
    logic signed [STAT_BITS-1:0] lowest_row_seen;
    logic [PIX_BITS-1:0]         color;
    logic [COORD_BITS-1:0]       dest_row;
    logic [COORD_BITS-1:0]       dest_col;
    logic                        write_enable;
  } sbl_out_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] screen_cols;
    logic [COORD_BITS-1:0] screen_rows;
  } sbl_cfg_t;

  typedef struct packed {
    logic                  write_enable;
    logic [COORD_BITS-1:0] dest_col;
    logic [COORD_BITS-1:0] dest_row;
    logic [PIX_BITS-1:0]   color;
    logic                  trk_en;
    logic [COORD_BITS-1:0] trk_row;
    logic [COORD_BITS-1:0] trk_col;
  } sbl_res_t;

endpackage

`default_nettype wire

[src/sbl_cfg.sv]
`default_nettype none

module sbl_cfg
  import sbl_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready,
  output sbl_cfg_t                      cfg_o
);

  logic [COORD_BITS-1:0] cols_q, cols_d;
  logic [COORD_BITS-1:0] rows_q, rows_d;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (wr_en) begin
      case (paddr[2])
        REG_SCREEN_COLS: cols_d = pwdata[COORD_BITS-1:0];
        REG_SCREEN_ROWS: rows_d = pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SCREEN_COLS: prdata = APB_DATA_BITS'(cols_q);
      REG_SCREEN_ROWS: prdata = APB_DATA_BITS'(rows_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= SCREEN_RESET;
      rows_q <= SCREEN_RESET;
    end else begin
      cols_q <= cols_d;
      rows_q <= rows_d;
    end
  end

  assign cfg_o.screen_cols = cols_q;
  assign cfg_o.screen_rows = rows_q;

endmodule

`default_nettype wire

[src/sbl_clip.sv]
`default_nettype none

module sbl_clip
  import sbl_pkg::*;
(
  input  sbl_in_t  item_i,
  input  sbl_cfg_t cfg_i,
  output sbl_res_t res_o
);

  localparam int CW = COORD_BITS;

  logic [CW+1:0] rx, rx_c, ry, ry_c;
  logic [CW-1:0] dx, dy;
  logic [CW:0]   sx, sy;
  logic [CW+2:0] w_full, h_full;
  logic [CW-1:0] w, h, w_m1;
  logic          row_vis, col_vis, trk_en, wen;
  logic [CW:0]   drow_full, i_full;
  logic [CW-1:0] drow, i_col, rstart, ocol;

  always_comb begin
    rx = {item_i.place_x[CW], item_i.place_x} + {2'b00, item_i.sprite_cols};
    ry = {item_i.place_y[CW], item_i.place_y} + {2'b00, item_i.sprite_rows};
    rx_c = ($signed(rx) > $signed({2'b00, cfg_i.screen_cols})) ?
           {2'b00, cfg_i.screen_cols} : rx;
    ry_c = ($signed(ry) > $signed({2'b00, cfg_i.screen_rows})) ?
           {2'b00, cfg_i.screen_rows} : ry;

    dx = item_i.place_x[CW] ? '0 : item_i.place_x[CW-1:0];
    dy = item_i.place_y[CW] ? '0 : item_i.place_y[CW-1:0];
    sx = item_i.place_x[CW] ? (~item_i.place_x + 1'b1) : '0;
    sy = item_i.place_y[CW] ? (~item_i.place_y + 1'b1) : '0;

    w_full = {rx_c[CW+1], rx_c} - {3'b000, dx};
    h_full = {ry_c[CW+1], ry_c} - {3'b000, dy};
    w      = w_full[CW+2] ? '0 : w_full[CW-1:0];
    h      = h_full[CW+2] ? '0 : h_full[CW-1:0];
    w_m1   = w - 1'b1;

    row_vis = ({1'b0, item_i.src_row} >= sy) &&
              ({2'b00, item_i.src_row} < ({1'b0, sy} + {2'b00, h}));
    col_vis = ({1'b0, item_i.src_col} >= sx) &&
              ({2'b00, item_i.src_col} < ({1'b0, sx} + {2'b00, w}));

    trk_en = (w != '0) && row_vis;
    wen    = trk_en && col_vis && (item_i.pixel != PIX_TRANSPARENT);

    drow_full = {1'b0, dy} + {1'b0, item_i.src_row} - sy;
    drow      = drow_full[CW-1:0];
    i_full    = {1'b0, item_i.src_col} - sx;
    i_col     = i_full[CW-1:0];
    rstart    = dx + (item_i.mirrored ? w_m1 : '0);
    ocol      = item_i.mirrored ? (dx + w_m1 - i_col) : (dx + i_col);

    res_o.write_enable = wen;
    res_o.dest_col     = wen ? ocol : '0;
    res_o.dest_row     = wen ? drow : '0;
    res_o.color        = wen ? item_i.pixel : '0;
    res_o.trk_en       = trk_en;
    res_o.trk_row      = drow;
    res_o.trk_col      = rstart;
  end

endmodule

`default_nettype wire

[src/clipped_transparent_sprite_blit_unit.sv]
// An input transfer is registered in the input register; the clip and address
// math sits between it and the result register on the master side. Throughput:
// one pixel per cycle while results are taken; when one stalls, the input
// register still takes one transfer and then holds until the result moves on.
// Reset (rst_ni, async, active low): pipeline empty, screen size 200 x 200,
// row/column trackers at +10000 (lowest) and -10000 (highest).
`default_nettype none

module clipped_transparent_sprite_blit_unit
  import sbl_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_tvalid_i,
  output logic                          s_tready_o,
  // place_x, place_y, sprite_cols, sprite_rows, mirrored, src_col, src_row, pixel
  input  wire logic [IN_BITS-1:0]       s_tdata_i,
  output logic                          m_tvalid_o,
  input  wire logic                     m_tready_i,
  // write_enable, dest_col, dest_row, color, lowest_row_seen, highest_row_seen,
  // lowest_col_seen, highest_col_seen
  output logic      [OUT_BITS-1:0]      m_tdata_o,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready
);

  sbl_cfg_t cfg;
  sbl_res_t res;
  sbl_in_t  in_q;
  logic     in_vld_q, in_vld_d;
  logic     out_vld_q, out_vld_d;
  logic     advance, in_take, out_load;
  logic                  we_q;
  logic [COORD_BITS-1:0] col_q, row_q;
  logic [PIX_BITS-1:0]   color_q;
  logic [TRK_BITS-1:0]   min_row_q, min_row_d, max_row_q, max_row_d;
  logic [TRK_BITS-1:0]   min_col_q, min_col_d, max_col_q, max_col_d;
  logic [TRK_BITS-1:0]   trk_row, trk_col;
  sbl_out_t              out_w;

  sbl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sbl_clip u_clip (
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign advance    = !out_vld_q || m_tready_i;
  assign s_tready_o = !in_vld_q || advance;
  assign in_take    = s_tvalid_i && s_tready_o;
  assign out_load   = advance && in_vld_q;

  assign in_vld_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_q);
  assign out_vld_d = advance ? in_vld_q : out_vld_q;

  assign trk_row = TRK_BITS'(res.trk_row);
  assign trk_col = TRK_BITS'(res.trk_col);

  always_comb begin
    min_row_d = min_row_q;
    max_row_d = max_row_q;
    min_col_d = min_col_q;
    max_col_d = max_col_q;
    if (out_load && res.trk_en) begin
      if ($signed(trk_row) < $signed(min_row_q)) min_row_d = trk_row;
      if ($signed(trk_row) > $signed(max_row_q)) max_row_d = trk_row;
      if ($signed(trk_col) < $signed(min_col_q)) min_col_d = trk_col;
      if ($signed(trk_col) > $signed(max_col_q)) max_col_d = trk_col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      min_row_q <= TRK_LO_INIT;
      max_row_q <= TRK_HI_INIT;
      min_col_q <= TRK_LO_INIT;
      max_col_q <= TRK_HI_INIT;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      min_row_q <= min_row_d;
      max_row_q <= max_row_d;
      min_col_q <= min_col_d;
      max_col_q <= max_col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= sbl_in_t'(s_tdata_i);
    end
    if (out_load) begin
      we_q    <= res.write_enable;
      col_q   <= res.dest_col;
      row_q   <= res.dest_row;
      color_q <= res.color;
    end
  end

  always_comb begin
    out_w.pad              = '0;
    out_w.write_enable     = we_q;
    out_w.dest_col         = col_q;
    out_w.dest_row         = row_q;
    out_w.color            = color_q;
    out_w.lowest_row_seen  = min_row_q[STAT_BITS-1:0];
    out_w.highest_row_seen = max_row_q[STAT_BITS-1:0];
    out_w.lowest_col_seen  = min_col_q[STAT_BITS-1:0];
    out_w.highest_col_seen = max_col_q[STAT_BITS-1:0];
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_w;

endmodule

`default_nettype wire

[src/sbl_checker.sv]
`default_nettype none

module sbl_checker
  import sbl_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_tready_o,
  input wire logic                m_tvalid_o,
  input wire logic                m_tready_i,
  input wire logic [OUT_BITS-1:0] m_tdata_o
);

  sbl_out_t o;
  assign o = sbl_out_t'(m_tdata_o);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid_o |-> s_tready_o)
    else $error("input stalled with empty output");

  a_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !o.write_enable |->
      o.dest_col == '0 && o.dest_row == '0 && o.color == '0)
    else $error("address or color not zero without write");

  a_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && o.write_enable |-> o.color != PIX_TRANSPARENT)
    else $error("transparent pixel written");

  a_row_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && o.write_enable |->
      o.lowest_row_seen <= $signed(STAT_BITS'(o.dest_row)) &&
      o.highest_row_seen >= $signed(STAT_BITS'(o.dest_row)))
    else $error("written row outside tracked range");

endmodule

bind clipped_transparent_sprite_blit_unit sbl_checker u_sbl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);

`default_nettype wire
